// File: src/fccw_pkg.sv
package fccw_pkg;

  localparam int unsigned CLUSTER_W = 28;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned BLOCK_W   = 48;
  localparam int unsigned COUNT_W   = 40;
  localparam int unsigned BRENT_W   = 30;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;

  // Masked FAT entry codes
  localparam logic [CLUSTER_W-1:0] FAT_BAD     = 28'hFFFFFF7;
  localparam logic [CLUSTER_W-1:0] FAT_EOC_MIN = 28'hFFFFFF8;
  localparam logic [CLUSTER_W-1:0] FAT_FREE    = 28'h0000000;

  // Input actions
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_ENTRY = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_VOLUME_BASE  = 3'd0;
  localparam logic [2:0] REG_DATA_START   = 3'd1;
  localparam logic [2:0] REG_SECTORS_PC   = 3'd2;
  localparam logic [2:0] REG_BLOCKS_PS    = 3'd3;
  localparam logic [2:0] REG_CLUSTER_TOT  = 3'd4;

  typedef enum logic [2:0] {
    STATUS_OK            = 3'd0,
    STATUS_OUT_OF_VOLUME = 3'd1,
    STATUS_BAD           = 3'd2,
    STATUS_FREE          = 3'd3,
    STATUS_LOOP          = 3'd4,
    STATUS_NO_CHAIN      = 3'd5
  } status_t;

  typedef struct packed {
    logic [31:0]          volume_base_block;
    logic [31:0]          data_offset;
    logic [7:0]           clus_sectors;
    logic [3:0]           sec_blocks;
    logic [CLUSTER_W-1:0] cluster_total;
  } cfg_t;

endpackage

// File: src/fat32_cluster_chain_walker.sv
// Channel | Direction | Transfer when       | Payload
// --------+-----------+---------------------+-------------------------------------------
// in_     | input     | in_valid & in_ready | action, value
// out_    | output    | out_valid&out_ready | fetch_cluster, frag_*, last, status
// cfg     | input     | psel&penable&pwrite | APB register write, paddr[4:2] = index
//
// One item at a time: in_ready is high only while the sequencer is idle.
// Items that end or fail without address arithmetic go from the check state
// straight to emit; a step that needs a block address also passes through
// the sec, blk, per and dec states, paced by the shared multiply-add unit,
// used three times in turn (sector, block, size).
// A stalled output holds the sequencer in its emit state; the result
// register frees as soon as the consumer takes it. Reset is synchronous and
// clears the walk and the configuration to their defaults.
module fat32_cluster_chain_walker
  import fccw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [VALUE_W-1:0]   in_value,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CLUSTER_W-1:0] out_fetch_cluster,
  output logic                 out_frag_valid,
  output logic [BLOCK_W-1:0]   out_frag_block,
  output logic [COUNT_W-1:0]   out_frag_blocks,
  output logic                 out_last,
  output logic [2:0]           out_status,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SEC, S_BLK, S_PER, S_DEC, S_EMIT
  } state_t;

  cfg_t cfg;

  state_t state_r;

  // latched item
  logic                 act_r;
  logic [VALUE_W-1:0]   val_r;
  logic                 begin_r;

  // walk state
  logic                 walking_r;
  logic [CLUSTER_W-1:0] cur_r;
  logic [CLUSTER_W-1:0] tort_r;
  logic [BRENT_W-1:0]   power_r;
  logic [BRENT_W-1:0]   steps_r;
  logic [BLOCK_W-1:0]   ofb_r;
  logic [COUNT_W-1:0]   ofc_r;
  logic [BLOCK_W-1:0]   nb_r;

  // staged result
  logic [CLUSTER_W-1:0] rs_fetch_r;
  logic                 rs_fv_r;
  logic [BLOCK_W-1:0]   rs_fb_r;
  logic [COUNT_W-1:0]   rs_fc_r;
  logic                 rs_last_r;
  status_t              rs_status_r;

  // output register
  logic                 out_valid_r;
  logic [CLUSTER_W-1:0] out_fetch_r;
  logic                 out_fv_r;
  logic [BLOCK_W-1:0]   out_fb_r;
  logic [COUNT_W-1:0]   out_fc_r;
  logic                 out_last_r;
  status_t              out_status_r;

  // shared multiply-add unit
  logic [36:0]          op_a;
  logic [7:0]           op_b;
  logic [31:0]          op_c;
  logic [BLOCK_W-1:0]   mres;

  // check-stage helpers
  logic [32:0]          vol_lim;
  logic                 val_in_vol;
  logic [CLUSTER_W-1:0] next_cl;
  logic                 next_in_vol;
  logic                 brent_hit;
  logic [CLUSTER_W-1:0] tort_eff;
  logic [BRENT_W-1:0]   steps_eff;
  logic                 contiguous;
  logic [11:0]          per;

  fccw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fccw_madd u_madd (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .op_c (op_c),
    .res  (mres)
  );

  // Feed the unit: sector offset, then block address, then cluster size
  always_comb begin
    unique case (state_r)
      S_SEC: begin
        op_a = {9'd0, cur_r - 28'd2};
        op_b = cfg.clus_sectors;
        op_c = cfg.data_offset;
      end
      S_BLK: begin
        op_a = mres[36:0];
        op_b = {4'd0, cfg.sec_blocks};
        op_c = cfg.volume_base_block;
      end
      default: begin
        op_a = {29'd0, cfg.clus_sectors};
        op_b = {4'd0, cfg.sec_blocks};
        op_c = '0;
      end
    endcase
  end

  // Range checks: valid clusters are 2 .. cluster_total + 1
  assign vol_lim     = {5'd0, cfg.cluster_total} + 33'd1;
  assign val_in_vol  = (val_r >= 32'd2) && ({1'b0, val_r} <= vol_lim);
  assign next_cl     = val_r[CLUSTER_W-1:0];
  assign next_in_vol = (next_cl >= 28'd2) && ({5'd0, next_cl} <= vol_lim);

  // Brent: on reaching the power, move the tortoise up and double the power
  assign brent_hit = (power_r == steps_r);
  assign tort_eff  = brent_hit ? cur_r : tort_r;
  assign steps_eff = brent_hit ? '0 : steps_r;

  assign per        = mres[11:0];
  assign contiguous = ({1'b0, ofb_r} + {9'd0, ofc_r}) == {1'b0, nb_r};

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walking_r   <= 1'b0;
      cur_r       <= '0;
      tort_r      <= '0;
      power_r     <= {{(BRENT_W-1){1'b0}}, 1'b1};
      steps_r     <= '0;
      ofb_r       <= '0;
      ofc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken, unless the emit state reloads it now
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r   <= in_action;
            val_r   <= in_value;
            state_r <= S_CHECK;
          end
        end

        S_CHECK: begin
          // defaults for every terminating result
          rs_fetch_r  <= '0;
          rs_fv_r     <= 1'b0;
          rs_fb_r     <= '0;
          rs_fc_r     <= '0;
          rs_last_r   <= 1'b1;
          rs_status_r <= STATUS_OK;
          state_r     <= S_EMIT;
          begin_r     <= 1'b0;
          if (act_r == ACT_START) begin
            // abandon any walk in progress
            walking_r <= 1'b0;
            cur_r     <= '0;
            if (val_r == '0) begin
              rs_status_r <= STATUS_OK;
            end else if (!val_in_vol) begin
              rs_status_r <= STATUS_OUT_OF_VOLUME;
            end else begin
              walking_r <= 1'b1;
              cur_r     <= val_r[CLUSTER_W-1:0];
              tort_r    <= val_r[CLUSTER_W-1:0];
              power_r   <= {{(BRENT_W-1){1'b0}}, 1'b1};
              steps_r   <= '0;
              begin_r   <= 1'b1;
              state_r   <= S_SEC;
            end
          end else if (!walking_r) begin
            rs_status_r <= STATUS_NO_CHAIN;
          end else begin
            priority if (next_cl >= FAT_EOC_MIN) begin
              rs_fv_r   <= 1'b1;
              rs_fb_r   <= ofb_r;
              rs_fc_r   <= ofc_r;
              walking_r <= 1'b0;
              cur_r     <= '0;
            end else if (next_cl == FAT_BAD) begin
              rs_status_r <= STATUS_BAD;
              walking_r   <= 1'b0;
              cur_r       <= '0;
            end else if (next_cl == FAT_FREE) begin
              rs_status_r <= STATUS_FREE;
              walking_r   <= 1'b0;
              cur_r       <= '0;
            end else begin
              tort_r  <= tort_eff;
              steps_r <= steps_eff + 30'd1;
              if (brent_hit) begin
                power_r <= {power_r[BRENT_W-2:0], 1'b0};
              end
              if (next_cl == tort_eff) begin
                rs_status_r <= STATUS_LOOP;
                walking_r   <= 1'b0;
                cur_r       <= '0;
              end else if (!next_in_vol) begin
                rs_status_r <= STATUS_OUT_OF_VOLUME;
                walking_r   <= 1'b0;
                cur_r       <= '0;
              end else begin
                cur_r   <= next_cl;
                state_r <= S_SEC;
              end
            end
          end
        end

        S_SEC: state_r <= S_BLK;

        S_BLK: state_r <= S_PER;

        S_PER: begin
          nb_r    <= mres;
          state_r <= S_DEC;
        end

        S_DEC: begin
          rs_fetch_r  <= cur_r;
          rs_last_r   <= 1'b0;
          rs_status_r <= STATUS_OK;
          rs_fv_r     <= 1'b0;
          rs_fb_r     <= '0;
          rs_fc_r     <= '0;
          if (begin_r) begin
            ofb_r <= nb_r;
            ofc_r <= {28'd0, per};
          end else if (contiguous) begin
            // extend the open fragment
            ofc_r <= ofc_r + {28'd0, per};
          end else begin
            // emit the old fragment and open a new one
            rs_fv_r <= 1'b1;
            rs_fb_r <= ofb_r;
            rs_fc_r <= ofc_r;
            ofb_r   <= nb_r;
            ofc_r   <= {28'd0, per};
          end
          state_r <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_fetch_r  <= rs_fetch_r;
            out_fv_r     <= rs_fv_r;
            out_fb_r     <= rs_fb_r;
            out_fc_r     <= rs_fc_r;
            out_last_r   <= rs_last_r;
            out_status_r <= rs_status_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fetch_cluster = out_fetch_r;
  assign out_frag_valid    = out_fv_r;
  assign out_frag_block    = out_fb_r;
  assign out_frag_blocks   = out_fc_r;
  assign out_last          = out_last_r;
  assign out_status        = out_status_r;

endmodule

// File: src/fccw_cfg.sv
module fccw_cfg
  import fccw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.volume_base_block <= '0;
      cfg_r.data_offset       <= '0;
      cfg_r.clus_sectors      <= 8'd1;
      cfg_r.sec_blocks        <= 4'd1;
      cfg_r.cluster_total     <= 28'd1;
    end else if (wr_en) begin
      unique case (idx)
        REG_VOLUME_BASE: cfg_r.volume_base_block <= pwdata;
        REG_DATA_START:  cfg_r.data_offset       <= pwdata;
        REG_SECTORS_PC:  cfg_r.clus_sectors      <= pwdata[7:0];
        REG_BLOCKS_PS:   cfg_r.sec_blocks        <= pwdata[3:0];
        REG_CLUSTER_TOT: cfg_r.cluster_total     <= pwdata[CLUSTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_VOLUME_BASE: prdata = cfg_r.volume_base_block;
      REG_DATA_START:  prdata = cfg_r.data_offset;
      REG_SECTORS_PC:  prdata = {24'd0, cfg_r.clus_sectors};
      REG_BLOCKS_PS:   prdata = {28'd0, cfg_r.sec_blocks};
      REG_CLUSTER_TOT: prdata = {4'd0, cfg_r.cluster_total};
      default:         prdata = '0;
    endcase
  end

endmodule

// File: src/fccw_madd.sv
module fccw_madd
  import fccw_pkg::*;
(
  input  logic               clk,
  input  logic [36:0]        op_a,
  input  logic [7:0]         op_b,
  input  logic [31:0]        op_c,
  output logic [BLOCK_W-1:0] res
);

  // res = op_a * op_b + op_c, registered
  logic [44:0]        prod;
  logic [BLOCK_W-1:0] res_nxt;
  logic [BLOCK_W-1:0] res_r;

  assign prod    = {8'd0, op_a} * {37'd0, op_b};
  assign res_nxt = {3'd0, prod} + {16'd0, op_c};
  assign res     = res_r;

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// File: src/fccw_checker.sv
module fccw_checker
  import fccw_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CLUSTER_W-1:0] out_fetch_cluster,
  input logic                 out_frag_valid,
  input logic [BLOCK_W-1:0]   out_frag_block,
  input logic [COUNT_W-1:0]   out_frag_blocks,
  input logic                 out_last,
  input logic [2:0]           out_status
);

  // a finished walk asks for no further entry
  a_last_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_fetch_cluster == '0)
    else $error("fetch cluster set on a final result");

  // an error never carries a fragment and always ends the walk
  a_error_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_OK) |-> out_last && !out_frag_valid)
    else $error("error result without last or with a fragment");

  // without a fragment the fragment fields read as zero
  a_no_frag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frag_valid |-> out_frag_block == '0 && out_frag_blocks == '0)
    else $error("fragment fields set without a fragment");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fetch_cluster)
      && $stable(out_status) && $stable(out_last))
    else $error("result changed while stalled");

endmodule

bind fat32_cluster_chain_walker fccw_checker u_fccw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_fetch_cluster (out_fetch_cluster),
  .out_frag_valid    (out_frag_valid),
  .out_frag_block    (out_frag_block),
  .out_frag_blocks   (out_frag_blocks),
  .out_last          (out_last),
  .out_status        (out_status)
);
